// ----- rtl/smrg_pkg.sv -----
// shared types and constants of the splitmix64 generator
package smrg_pkg;

  localparam int unsigned DataW = 64;

  localparam logic [DataW-1:0] DefaultSeed = 64'h853c49e6748fea9b;
  localparam logic [DataW-1:0] GoldenInc   = 64'h9e3779b97f4a7c15;
  localparam logic [DataW-1:0] MixMulA     = 64'hbf58476d1ce4e5b9;
  localparam logic [DataW-1:0] MixMulB     = 64'h94d049bb133111eb;

  localparam int unsigned ShiftA = 30;
  localparam int unsigned ShiftB = 27;
  localparam int unsigned ShiftC = 31;

  // multiplier works on one 16-bit digit of the second operand per cycle
  localparam int unsigned MulDigitW = 16;
  localparam int unsigned MulSteps  = DataW / MulDigitW;
  localparam int unsigned MulCntW   = $clog2(MulSteps);
  localparam int unsigned MulProdW  = DataW + MulDigitW;

  // remainder unit retires one dividend bit per cycle
  localparam int unsigned RemCntW = $clog2(DataW);

  typedef enum logic [1:0] {
    OpSeed    = 2'd0,
    OpDraw    = 2'd1,
    OpBounded = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StMul1Go,
    StMul1,
    StMul2Go,
    StMul2,
    StRemGo,
    StRem,
    StDone
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ----- rtl/smrg_mul.sv -----
// iterative 64x64 multiplier keeping the low 64 product bits
module smrg_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [smrg_pkg::DataW-1:0]   a_i,
  input  logic [smrg_pkg::DataW-1:0]   b_i,
  output logic [smrg_pkg::DataW-1:0]   product_o,
  output smrg_pkg::unit_sts_t          sts_o
);

  logic [smrg_pkg::DataW-1:0]    a_q, a_d;
  logic [smrg_pkg::DataW-1:0]    b_q, b_d;
  logic [smrg_pkg::DataW-1:0]    acc_q, acc_d;
  logic [smrg_pkg::MulCntW-1:0]  cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [smrg_pkg::MulProdW-1:0] part;

  assign part = a_q * b_q[smrg_pkg::MulDigitW-1:0];

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + part[smrg_pkg::DataW-1:0];
      a_d   = a_q << smrg_pkg::MulDigitW;
      b_d   = b_q >> smrg_pkg::MulDigitW;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == smrg_pkg::MulCntW'(smrg_pkg::MulSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign product_o  = acc_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// ----- rtl/smrg_rem.sv -----
// radix-2 restoring unit for the 64-bit remainder
module smrg_rem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [smrg_pkg::DataW-1:0]   dividend_i,
  input  logic [smrg_pkg::DataW-1:0]   divisor_i,
  output logic [smrg_pkg::DataW-1:0]   rem_o,
  output smrg_pkg::unit_sts_t          sts_o
);

  logic [smrg_pkg::DataW-1:0]   rem_q, rem_d;
  logic [smrg_pkg::DataW-1:0]   num_q, num_d;
  logic [smrg_pkg::DataW-1:0]   div_q, div_d;
  logic [smrg_pkg::RemCntW-1:0] cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [smrg_pkg::DataW:0]     trial;
  logic [smrg_pkg::DataW:0]     diff;

  assign trial = {rem_q, num_q[smrg_pkg::DataW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      num_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[smrg_pkg::DataW-1:0];
      end else begin
        rem_d = trial[smrg_pkg::DataW-1:0];
      end
      num_d = num_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == smrg_pkg::RemCntW'(smrg_pkg::DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    div_q <= div_d;
  end

  assign rem_o      = rem_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// ----- rtl/splitmix_random_generator_unit.sv -----
// splitmix64 generator top level: sequencer, state word and output register
// One request at a time. A reseed (operation 0) or an unused code finishes in the accept
// cycle and gives no result. A plain draw runs two 64x64 multiplies on one shared
// multiplier that consumes a 16-bit digit per cycle, each launched from its own start
// state, and then loads the output register once it is free. A bounded draw adds the
// radix-2 remainder unit, one dividend bit per cycle; a zero bound gives zero without
// running either unit. in_ready_o is high only while the sequencer is idle.
// The result sits in an output register, so the next request may be accepted while the
// previous result still waits.
module splitmix_random_generator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 operation_i,
  input  logic [smrg_pkg::DataW-1:0] seed_value_i,
  input  logic [smrg_pkg::DataW-1:0] bound_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [smrg_pkg::DataW-1:0] random_value_o
);

  smrg_pkg::state_e           state_q, state_d;
  logic [smrg_pkg::DataW-1:0] gen_q, gen_d;
  logic [smrg_pkg::DataW-1:0] z_q, z_d;
  logic [smrg_pkg::DataW-1:0] bound_q, bound_d;
  logic                       bounded_q, bounded_d;
  logic                       out_valid_q, out_valid_d;
  logic [smrg_pkg::DataW-1:0] out_data_q, out_data_d;

  logic                       accept;
  logic                       out_load;
  logic [smrg_pkg::DataW-1:0] gen_adv;
  logic                       mul_start;
  logic [smrg_pkg::DataW-1:0] mul_b;
  logic [smrg_pkg::DataW-1:0] mul_p;
  smrg_pkg::unit_sts_t        mul_sts;
  logic                       rem_start;
  logic [smrg_pkg::DataW-1:0] rem_r;
  smrg_pkg::unit_sts_t        rem_sts;

  smrg_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (z_q),
    .b_i       (mul_b),
    .product_o (mul_p),
    .sts_o     (mul_sts)
  );

  smrg_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (z_q),
    .divisor_i  (bound_q),
    .rem_o      (rem_r),
    .sts_o      (rem_sts)
  );

  assign accept  = in_valid_i && in_ready_o;
  assign gen_adv = gen_q + smrg_pkg::GoldenInc;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      smrg_pkg::StIdle: begin
        if (accept) begin
          case (operation_i)
            smrg_pkg::OpDraw:    state_d = smrg_pkg::StMul1Go;
            smrg_pkg::OpBounded: begin
              state_d = (bound_i == '0) ? smrg_pkg::StDone : smrg_pkg::StMul1Go;
            end
            default:             state_d = smrg_pkg::StIdle;
          endcase
        end
      end
      smrg_pkg::StMul1Go: state_d = smrg_pkg::StMul1;
      smrg_pkg::StMul1: begin
        if (mul_sts.done) state_d = smrg_pkg::StMul2Go;
      end
      smrg_pkg::StMul2Go: state_d = smrg_pkg::StMul2;
      smrg_pkg::StMul2: begin
        if (mul_sts.done) state_d = bounded_q ? smrg_pkg::StRemGo : smrg_pkg::StDone;
      end
      smrg_pkg::StRemGo: state_d = smrg_pkg::StRem;
      smrg_pkg::StRem: begin
        if (rem_sts.done) state_d = smrg_pkg::StDone;
      end
      smrg_pkg::StDone: begin
        if (out_load) state_d = smrg_pkg::StIdle;
      end
      default: state_d = smrg_pkg::StIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = (state_q == smrg_pkg::StIdle);
    mul_start  = (state_q == smrg_pkg::StMul1Go) || (state_q == smrg_pkg::StMul2Go);
    mul_b      = (state_q == smrg_pkg::StMul1Go) ? smrg_pkg::MixMulA : smrg_pkg::MixMulB;
    rem_start  = (state_q == smrg_pkg::StRemGo);
    out_load   = (state_q == smrg_pkg::StDone) && (!out_valid_q || out_ready_i);
  end

  // datapath
  always_comb begin
    gen_d       = gen_q;
    z_d         = z_q;
    bound_d     = bound_q;
    bounded_d   = bounded_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      smrg_pkg::StIdle: begin
        if (accept) begin
          case (operation_i)
            smrg_pkg::OpSeed: begin
              gen_d = (seed_value_i != '0) ? seed_value_i : smrg_pkg::DefaultSeed;
            end
            smrg_pkg::OpDraw: begin
              gen_d     = gen_adv;
              z_d       = gen_adv ^ (gen_adv >> smrg_pkg::ShiftA);
              bounded_d = 1'b0;
            end
            smrg_pkg::OpBounded: begin
              bound_d = bound_i;
              if (bound_i == '0) begin
                z_d = '0;
              end else begin
                gen_d     = gen_adv;
                z_d       = gen_adv ^ (gen_adv >> smrg_pkg::ShiftA);
                bounded_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      smrg_pkg::StMul1: begin
        if (mul_sts.done) z_d = mul_p ^ (mul_p >> smrg_pkg::ShiftB);
      end
      smrg_pkg::StMul2: begin
        if (mul_sts.done) z_d = mul_p ^ (mul_p >> smrg_pkg::ShiftC);
      end
      smrg_pkg::StRem: begin
        if (rem_sts.done) z_d = rem_r;
      end
      smrg_pkg::StDone: begin
        if (out_load) begin
          out_data_d  = z_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smrg_pkg::StIdle;
      gen_q       <= smrg_pkg::DefaultSeed;
      bounded_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      bounded_q   <= bounded_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q        <= z_d;
    bound_q    <= bound_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_data_q;

`ifndef SYNTHESIS
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_sts.busy && rem_sts.busy))
    else $error("multiplier and remainder unit busy together");

  a_seed_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == smrg_pkg::OpSeed && seed_value_i != '0)
    |=> (gen_q == $past(seed_value_i)))
    else $error("reseed did not load the state");

  a_rem_below_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smrg_pkg::StRem && rem_sts.done) |-> (rem_r < bound_q))
    else $error("remainder not below bound");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("pending result overwritten");
`endif

endmodule
